FILE: sv/e2q_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the angle to quaternion block.
package e2q_pkg;

  localparam int AngleWidth  = 16;
  localparam int QuatWidth   = 16;
  localparam int IterDefault = 16;
  localparam int IterMax     = 30;

  // angle accumulator: |t| <= 2^31, so 34 bits signed gives headroom
  localparam int AccWidth = 34;
  // x, y stay below 2^30 in magnitude
  localparam int XyWidth  = 32;
  // rounded sine and cosine, Q.15 in [-32768, 32768]
  localparam int ScWidth  = 17;

  localparam logic signed [AccWidth-1:0] HalfPi = 34'sd1686629713;
  localparam logic signed [AccWidth-1:0] Pi     = 34'sd3373259426;
  localparam logic signed [XyWidth-1:0]  Gain   = 32'sd652032874;
  localparam logic signed [QuatWidth-1:0] QOne  = 16'sd16384;

  typedef logic signed [AccWidth-1:0] acc_t;
  typedef logic signed [XyWidth-1:0]  xy_t;
  typedef logic signed [ScWidth-1:0]  sc_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    acc_t t;
    logic flip;
  } rot_t;

  function automatic acc_t atan_q30(input int i);
    acc_t r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      default: r = (i < IterMax) ? (acc_t'(1) <<< (30 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: one micro-rotation per register stage, three lanes.
module e2q_cordic #(
  parameter int Iterations = e2q_pkg::IterDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [e2q_pkg::AngleWidth-1:0] angle [3],
  output logic                          out_valid,
  output e2q_pkg::sc_t                  sin_q15 [3],
  output e2q_pkg::sc_t                  cos_q15 [3]
);
  import e2q_pkg::*;

  localparam int Steps = (Iterations > IterMax) ? IterMax : Iterations;

  rot_t stage [Steps+1][3];
  logic vld   [Steps+1];

  // folding stage: half angle is the negated input, in Q.14, scaled to Q.30
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      acc_t t;
      t = -(acc_t'(angle[l]) <<< 16);
      stage[0][l].x <= Gain;
      stage[0][l].y <= '0;
      if (t > HalfPi) begin
        stage[0][l].t    <= Pi - t;
        stage[0][l].flip <= 1'b1;
      end else if (t < -HalfPi) begin
        stage[0][l].t    <= -Pi - t;
        stage[0][l].flip <= 1'b1;
      end else begin
        stage[0][l].t    <= t;
        stage[0][l].flip <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Steps; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k <= Steps; k++) vld[k] <= vld[k-1];
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        stage[i+1][l].flip <= stage[i][l].flip;
        if (stage[i][l].t >= 0) begin
          stage[i+1][l].x <= stage[i][l].x - (stage[i][l].y >>> i);
          stage[i+1][l].y <= stage[i][l].y + (stage[i][l].x >>> i);
          stage[i+1][l].t <= stage[i][l].t - atan_q30(i);
        end else begin
          stage[i+1][l].x <= stage[i][l].x + (stage[i][l].y >>> i);
          stage[i+1][l].y <= stage[i][l].y - (stage[i][l].x >>> i);
          stage[i+1][l].t <= stage[i][l].t + atan_q30(i);
        end
      end
    end
  end

  // output stage: sign fix and round half up to Q.15
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      xy_t xf;
      xf = stage[Steps][l].flip ? -stage[Steps][l].x : stage[Steps][l].x;
      sin_q15[l] <= sc_t'((stage[Steps][l].y + xy_t'(16384)) >>> 15);
      cos_q15[l] <= sc_t'((xf + xy_t'(16384)) >>> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vld[Steps];
  end

endmodule

FILE: sv/e2q_combine.sv
// Triple products, sums, rounding and saturation into the four quaternion components.
module e2q_combine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  e2q_pkg::sc_t         sin_q15 [3],
  input  e2q_pkg::sc_t         cos_q15 [3],
  output logic                 out_valid,
  output logic signed [e2q_pkg::QuatWidth-1:0] quat [4]
);
  import e2q_pkg::*;

  typedef logic signed [2*ScWidth-1:0] p2_t;
  typedef logic signed [3*ScWidth-1:0] p3_t;
  typedef logic signed [3*ScWidth:0]   s_t;

  // stage 1: roll by pitch pair products, yaw held
  p2_t  cc, cs, sc, ss;
  sc_t  sy1, cy1;
  // stage 2: eight triple products
  p3_t  ccc, sss, csc, scs, ccs, ssc, scc, css;
  // stage 3: sums
  s_t   sum [4];
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    cc  <= p2_t'(cos_q15[0]) * p2_t'(cos_q15[1]);
    cs  <= p2_t'(cos_q15[0]) * p2_t'(sin_q15[1]);
    sc  <= p2_t'(sin_q15[0]) * p2_t'(cos_q15[1]);
    ss  <= p2_t'(sin_q15[0]) * p2_t'(sin_q15[1]);
    sy1 <= sin_q15[2];
    cy1 <= cos_q15[2];

    ccc <= p3_t'(cc) * p3_t'(cy1);
    sss <= p3_t'(ss) * p3_t'(sy1);
    csc <= p3_t'(cs) * p3_t'(cy1);
    scs <= p3_t'(sc) * p3_t'(sy1);
    ccs <= p3_t'(cc) * p3_t'(sy1);
    ssc <= p3_t'(ss) * p3_t'(cy1);
    scc <= p3_t'(sc) * p3_t'(cy1);
    css <= p3_t'(cs) * p3_t'(sy1);

    sum[0] <= s_t'(ccc) + s_t'(sss);
    sum[1] <= s_t'(csc) + s_t'(scs);
    sum[2] <= s_t'(ccs) - s_t'(ssc);
    sum[3] <= s_t'(scc) - s_t'(css);

    for (int k = 0; k < 4; k++) begin
      s_t r;
      r = (sum[k] + (s_t'(1) <<< 30)) >>> 31;
      if (r > s_t'(QOne))       quat[k] <= QOne;
      else if (r < -s_t'(QOne)) quat[k] <= -QOne;
      else                      quat[k] <= QuatWidth'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; out_valid <= v3;
    end
  end

endmodule

FILE: sv/euler_angles_to_quaternion.sv
// Top level: ZYX Euler angles to quaternion, fully pipelined.
// Usage:
//   Pulse start with roll_angle, pitch_angle and yaw_angle (Q3.13 radians).
//   busy is always low: a request is taken on every cycle that start is high.
//   Results appear on quat_w/x/y/z (Q1.14, clamped to +-1.0) with done high
//   for exactly one cycle, in request order.
// Pipeline: from the accepting edge to done a request passes one folding
//   stage, one stage per micro-rotation, a rounding stage, then four
//   stages of products, sums and saturation; iteration counts above 30
//   count as 30.
// Throughput: one request per cycle; each CORDIC micro-rotation and each
//   multiply has its own register stage.
// Reset: rst clears all valid bits; requests in flight are dropped.
// The receiver cannot stall; results are presented once and must be taken.
// Output component mapping: z carries the roll-style formula, x the pitch
//   style, y the yaw style.
module euler_angles_to_quaternion #(
  parameter int CORDIC_ITERATIONS = e2q_pkg::IterDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [e2q_pkg::AngleWidth-1:0] roll_angle,
  input  logic signed [e2q_pkg::AngleWidth-1:0] pitch_angle,
  input  logic signed [e2q_pkg::AngleWidth-1:0] yaw_angle,
  output logic done,
  output logic signed [e2q_pkg::QuatWidth-1:0] quat_w,
  output logic signed [e2q_pkg::QuatWidth-1:0] quat_x,
  output logic signed [e2q_pkg::QuatWidth-1:0] quat_y,
  output logic signed [e2q_pkg::QuatWidth-1:0] quat_z
);
  import e2q_pkg::*;

  logic signed [AngleWidth-1:0] angle [3];
  sc_t  s [3];
  sc_t  c [3];
  logic sc_valid;
  logic signed [QuatWidth-1:0] q [4];

  assign busy = 1'b0;
  assign angle[0] = roll_angle;
  assign angle[1] = pitch_angle;
  assign angle[2] = yaw_angle;

  e2q_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cordic (
    .clk, .rst, .in_valid(start), .angle,
    .out_valid(sc_valid), .sin_q15(s), .cos_q15(c)
  );

  e2q_combine u_combine (
    .clk, .rst, .in_valid(sc_valid), .sin_q15(s), .cos_q15(c),
    .out_valid(done), .quat(q)
  );

  assign quat_w = q[0];
  assign quat_x = q[1];
  assign quat_y = q[2];
  assign quat_z = q[3];

endmodule

FILE: sv/e2q_checker.sv
// Port-level checks for the angle to quaternion block, bound to the top level.
module e2q_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [15:0] quat_w,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z
);
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384))
    else $error("quat_w out of range");
  a_xyz_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
              quat_y <= 16'sd16384 && quat_y >= -16'sd16384 &&
              quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
    else $error("quaternion component out of range");
endmodule

bind euler_angles_to_quaternion e2q_checker u_e2q_checker (.*);

FILE: tb/euler_angles_to_quaternion_chk.sv
// Checker for the angle to quaternion block: predicts each result and compares.
`timescale 1ns / 100ps
module euler_angles_to_quaternion_chk #(
  parameter int CORDIC_ITERATIONS = e2q_pkg::IterDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic done,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output int   fail_count,
  output int   pending,
  output int   quat_seen
);

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  quat_t quat_expected[$];

  function automatic longint half_atan(input int i);
    longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    return longint'(1) << (30 - i);
  endfunction

  // sine and cosine (Q.15) of a half angle in Q.14
  function automatic void half_angle_sincos(input longint h, output longint s,
                                            output longint c);
    longint t, x, y, nx, dx, dy;
    bit     flip;
    int     n;
    t = h * 65536;
    flip = 0;
    x = 652032874;
    y = 0;
    n = (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;
    if (t > 64'sd1686629713) begin
      t = 64'sd3373259426 - t;
      flip = 1;
    end else if (t < -64'sd1686629713) begin
      t = -64'sd3373259426 - t;
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        nx = x - dx;
        y = y + dy;
        t -= half_atan(i);
      end else begin
        nx = x + dx;
        y = y - dy;
        t += half_atan(i);
      end
      x = nx;
    end
    if (flip) x = -x;
    s = (y + 16384) >>> 15;
    c = (x + 16384) >>> 15;
  endfunction

  function automatic logic signed [15:0] round_clamp(input longint v);
    longint r;
    r = (v + (longint'(1) << 30)) >>> 31;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quat(input logic signed [15:0] ra,
                                         input logic signed [15:0] pa,
                                         input logic signed [15:0] ya);
    longint sr, cr, sp, cp, sy, cy;
    quat_t  q;
    half_angle_sincos(-longint'(ra), sr, cr);
    half_angle_sincos(-longint'(pa), sp, cp);
    half_angle_sincos(-longint'(ya), sy, cy);
    q.w = round_clamp(cr * cp * cy + sr * sp * sy);
    q.x = round_clamp(cr * sp * cy + sr * cp * sy);
    q.y = round_clamp(cr * cp * sy - sr * sp * cy);
    q.z = round_clamp(sr * cp * cy - cr * sp * sy);
    return q;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    quat_seen = 0;
  end

  always @(posedge clk) begin
    quat_t want;
    if (!rst && done) begin
      quat_seen++;
      if (quat_expected.size() == 0) begin
        $display("%0t mismatch: result with no request waiting", $realtime);
        fail_count++;
      end else begin
        want = quat_expected.pop_front();
        if (quat_w !== want.w) report("quat_w", quat_w, want.w);
        if (quat_x !== want.x) report("quat_x", quat_x, want.x);
        if (quat_y !== want.y) report("quat_y", quat_y, want.y);
        if (quat_z !== want.z) report("quat_z", quat_z, want.z);
      end
    end
    if (!rst && start && !busy)
      quat_expected.push_back(predict_quat(roll_angle, pitch_angle, yaw_angle));
    pending = quat_expected.size();
  end

endmodule

FILE: tb/euler_angles_to_quaternion_tb.sv
// Testbench top: drives angle requests and reports the verdict.
`timescale 1ns / 100ps
module euler_angles_to_quaternion_tb;

  localparam int Latency = e2q_pkg::IterDefault + 6;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
  logic done;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  int fail_count, pending, quat_seen;
  int sent = 0;

  always #5 clk = ~clk;

  euler_angles_to_quaternion u_top (.*);
  euler_angles_to_quaternion_chk u_chk (.*);

  // one request; idle_pct is the chance of an idle cycle before it
  task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] y, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    roll_angle <= r;
    pitch_angle <= p;
    yaw_angle <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(7))
      0: return 16'(32'h8000 + $urandom_range(15));
      1: return 16'(32'h7fff - $urandom_range(15));
      2: return 16'($urandom_range(40) - 20);
      // near +-pi/2 and near the folding points at +-pi, in Q3.13
      3: return 16'(12868 + $urandom_range(8) - 4);
      4: return 16'(-12868 + int'($urandom_range(8)) - 4);
      5: return 16'(($urandom_range(1) ? 25736 : -25736) + int'($urandom_range(8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] edges[8] = '{16'h8000, 16'h8001, 16'h7fff, 16'h0000,
                               16'h0001, 16'hffff, 16'd12868, 16'd25736};
    int idle_pct[4] = '{0, 57, 0, 29};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8], 0);
    for (int i = 0; i < 8; i++) send_angles(edges[i], edges[i], edges[i], 0);
    send_angles(16'h0000, 16'h8000, 16'h0000, 0);
    send_angles(16'h8000, 16'h0000, 16'h7fff, 10);
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 485; k++)
        send_angles(rand_angle(), rand_angle(), rand_angle(), idle_pct[ph]);
      // hold off until every request has come back
      start <= 0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d angle requests, checked %0d quaternions over four idling phases.",
             sent, quat_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
